// ===== rtl/wheel_speed_to_fan_duty_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the wheel speed to fan duty block
// Clocked assertion shorthands, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_TO_FAN_DUTY_TOP_ASSERT_SVH
`define WHEEL_SPEED_TO_FAN_DUTY_TOP_ASSERT_SVH

// checked outside reset
`define WSFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define WSFD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared constants, codes and control structs of the wheel speed to fan duty block.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   localparam int DUTY_BITS = 10;
   localparam int QBITS     = (DUTY_BITS + 1 > 14) ? DUTY_BITS + 1 : 14;
   localparam int NUM_W     = 60;
   localparam int DEN_W     = 35;
   localparam int CNT_W     = $clog2(QBITS + 1);
   localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};

   localparam logic [7:0] FLAG_WHEEL    = 8'h01;
   localparam logic [7:0] WHEEL_MIN_LEN = 8'd7;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_FIRST    = 3'd1,
      ST_NO_WHEEL = 3'd2,
      ST_SHORT    = 3'd3,
      ST_ZERO_INT = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_CIRC      = 3'd0,
      REG_MIN_SPEED = 3'd1,
      REG_MAX_SPEED = 3'd2,
      REG_SPEED_CAP = 3'd3,
      REG_FLOOR_PCT = 3'd4,
      REG_CURVE_PCT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic div_start_spd;
      logic div_start_duty;
      logic spd_write;
      logic sq;
      logic dmul;
      logic duty_zero;
      logic duty_full;
      logic duty_write;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      status_type cls;
      logic       div_done;
      logic       spd_zero;
      logic       spd_below;
      logic       curve_empty;
   } stat_type;

endpackage

// ===== rtl/wsfd_div.sv =====
// ----------------------------------------------------------------------------
// wsfd_div
// Restoring divider, one quotient bit per cycle; top bit flags overflow.
// ----------------------------------------------------------------------------
module wsfd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wsfd_pkg::NUM_W-1:0]    dividend,
   input  logic [wsfd_pkg::DEN_W-1:0]    divisor,
   output logic [wsfd_pkg::QBITS:0]      quotient,
   output logic                          done
);

   localparam int SH_W = wsfd_pkg::DEN_W + wsfd_pkg::QBITS;

   logic [wsfd_pkg::NUM_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]            dsh_ff, dsh_in;
   logic [wsfd_pkg::QBITS:0]   q_ff, q_in;
   logic [wsfd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       ge;

   assign ge = rem_ff >= wsfd_pkg::NUM_W'(dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = {divisor, {wsfd_pkg::QBITS{1'b0}}};
         q_in    = '0;
         cnt_in  = wsfd_pkg::CNT_W'(wsfd_pkg::QBITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - wsfd_pkg::NUM_W'(dsh_ff);
         end
         q_in   = {q_ff[wsfd_pkg::QBITS-1:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/wsfd_dp.sv =====
// ----------------------------------------------------------------------------
// wsfd_dp
// Datapath: config registers, sample history, speed and duty arithmetic.
// ----------------------------------------------------------------------------
module wsfd_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  wsfd_pkg::cmd_type               cmd,
   output wsfd_pkg::stat_type              stat,
   input  wsfd_pkg::status_type            out_status,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [15:0]                     csr_wdata,
   input  logic [7:0]                      req_packet_length,
   input  logic [7:0]                      req_flags,
   input  logic [31:0]                     req_wheel_revs,
   input  logic [15:0]                     req_wheel_event_time,
   output logic [13:0]                     rsp_speed,
   output logic [wsfd_pkg::DUTY_BITS-1:0]  rsp_duty,
   output logic [2:0]                      rsp_status
);

   localparam int DB = wsfd_pkg::DUTY_BITS;
   localparam int QB = wsfd_pkg::QBITS;

   logic [11:0] circ_ff;
   logic [13:0] min_ff, max_ff, cap_ff;
   logic [6:0]  fpct_ff;
   logic [7:0]  cpct_ff;

   logic [31:0] prev_revs_ff;
   logic [15:0] prev_time_ff;
   logic        first_ff;
   logic [13:0] speed_ff, speed_in;
   logic [DB-1:0] duty_ff;

   logic [31:0] drevs_ff;
   logic [15:0] dtime_ff;
   logic [15:0] dtime_c;
   logic [43:0] prod_ff;
   logic [27:0] dsq_ff, xsq_ff;
   logic [34:0] fterm_ff;
   logic [35:0] cterm_ff;

   logic [13:0] out_speed_ff;
   logic [DB-1:0] out_duty_ff;
   logic [2:0]  out_status_ff;

   wsfd_pkg::status_type cls;
   logic [47:0] spd_num;
   logic [22:0] spd_den;
   logic [13:0] d_c, x_c;
   logic [36:0] dsum;
   logic [36+DB:0] duty_num;
   logic [34:0] duty_den;
   logic [wsfd_pkg::NUM_W-1:0] dividend;
   logic [wsfd_pkg::DEN_W-1:0] divisor;
   logic [QB:0]  quot;
   logic [QB-1:0] q_lo;
   logic         div_done;
   logic [DB-1:0] duty_res;

   assign dtime_c = req_wheel_event_time - prev_time_ff;

   always_comb begin
      if (req_packet_length == 8'd0) begin
         cls = wsfd_pkg::ST_SHORT;
      end else if ((req_flags & wsfd_pkg::FLAG_WHEEL) == 8'd0) begin
         cls = wsfd_pkg::ST_NO_WHEEL;
      end else if (req_packet_length < wsfd_pkg::WHEEL_MIN_LEN) begin
         cls = wsfd_pkg::ST_SHORT;
      end else if (first_ff) begin
         cls = wsfd_pkg::ST_FIRST;
      end else if (dtime_c == 16'd0) begin
         cls = wsfd_pkg::ST_ZERO_INT;
      end else begin
         cls = wsfd_pkg::ST_UPDATED;
      end
   end

   assign spd_num  = {1'b0, prod_ff, 3'b000} + {4'b0000, prod_ff};
   assign spd_den  = ({7'd0, dtime_ff} << 6) + ({7'd0, dtime_ff} << 5)
                   + ({7'd0, dtime_ff} << 2);
   assign d_c      = max_ff - min_ff;
   assign x_c      = speed_ff - min_ff;
   assign dsum     = {2'b00, fterm_ff} + {1'b0, cterm_ff};
   assign duty_num = {dsum, {DB{1'b0}}} - (37 + DB)'(dsum);
   assign duty_den = ({7'd0, dsq_ff} << 6) + ({7'd0, dsq_ff} << 5) + ({7'd0, dsq_ff} << 2);

   always_comb begin
      if (cmd.div_start_duty) begin
         dividend = wsfd_pkg::NUM_W'(duty_num);
         divisor  = wsfd_pkg::DEN_W'(duty_den);
      end else begin
         dividend = wsfd_pkg::NUM_W'({spd_num, 12'd0});
         divisor  = wsfd_pkg::DEN_W'(spd_den);
      end
   end

   wsfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start_spd | cmd.div_start_duty),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quot),
      .done     (div_done)
   );

   assign q_lo = quot[QB-1:0];

   always_comb begin
      if (quot[QB] || (q_lo > QB'(cap_ff))) begin
         speed_in = cap_ff;
      end else begin
         speed_in = q_lo[13:0];
      end
      if (quot[QB] || (q_lo > QB'(wsfd_pkg::DUTY_FULL))) begin
         duty_res = wsfd_pkg::DUTY_FULL;
      end else begin
         duty_res = q_lo[DB-1:0];
      end
   end

   assign stat.cls         = cls;
   assign stat.div_done    = div_done;
   assign stat.spd_zero    = (speed_ff == 14'd0);
   assign stat.spd_below   = (speed_ff < min_ff);
   assign stat.curve_empty = (max_ff <= min_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff      <= 12'd2146;
         min_ff       <= 14'd300;
         max_ff       <= 14'd3500;
         cap_ff       <= 14'd9900;
         fpct_ff      <= 7'd4;
         cpct_ff      <= 8'd98;
         prev_revs_ff <= '0;
         prev_time_ff <= '0;
         first_ff     <= 1'b1;
         speed_ff     <= '0;
         duty_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               wsfd_pkg::REG_CIRC:      circ_ff <= csr_wdata[11:0];
               wsfd_pkg::REG_MIN_SPEED: min_ff  <= csr_wdata[13:0];
               wsfd_pkg::REG_MAX_SPEED: max_ff  <= csr_wdata[13:0];
               wsfd_pkg::REG_SPEED_CAP: cap_ff  <= csr_wdata[13:0];
               wsfd_pkg::REG_FLOOR_PCT: fpct_ff <= csr_wdata[6:0];
               wsfd_pkg::REG_CURVE_PCT: cpct_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            if (cls == wsfd_pkg::ST_FIRST || cls == wsfd_pkg::ST_ZERO_INT
                || cls == wsfd_pkg::ST_UPDATED) begin
               prev_revs_ff <= req_wheel_revs;
               prev_time_ff <= req_wheel_event_time;
               first_ff     <= 1'b0;
            end
            if (cls == wsfd_pkg::ST_ZERO_INT) begin
               speed_ff <= '0;
               duty_ff  <= '0;
            end
         end
         if (cmd.spd_write) begin
            speed_ff <= speed_in;
         end
         if (cmd.duty_zero) begin
            duty_ff <= '0;
         end else if (cmd.duty_full) begin
            duty_ff <= wsfd_pkg::DUTY_FULL;
         end else if (cmd.duty_write) begin
            duty_ff <= duty_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         drevs_ff <= req_wheel_revs - prev_revs_ff;
         dtime_ff <= dtime_c;
      end
      if (cmd.mul) begin
         prod_ff <= drevs_ff * circ_ff;
      end
      if (cmd.sq) begin
         dsq_ff <= d_c * d_c;
         xsq_ff <= x_c * x_c;
      end
      if (cmd.dmul) begin
         fterm_ff <= fpct_ff * dsq_ff;
         cterm_ff <= cpct_ff * xsq_ff;
      end
      if (cmd.out_load) begin
         out_speed_ff  <= speed_ff;
         out_duty_ff   <= duty_ff;
         out_status_ff <= out_status;
      end
   end

   assign rsp_speed  = out_speed_ff;
   assign rsp_duty   = out_duty_ff;
   assign rsp_status = out_status_ff;

endmodule

// ===== rtl/wsfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsfd_ctrl
// Sequencer: steps the datapath through speed and duty and runs the handshakes.
// ----------------------------------------------------------------------------
module wsfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  wsfd_pkg::stat_type     stat,
   output wsfd_pkg::cmd_type      cmd,
   output wsfd_pkg::status_type   out_status
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_LDS, S_WDS, S_CHK, S_SQ, S_DMUL, S_LDD, S_WDD, S_DUTY, S_FIN
   } state_type;

   state_type            state_ff, state_in;
   wsfd_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               status_in   = stat.cls;
               state_in    = (stat.cls == wsfd_pkg::ST_UPDATED) ? S_MUL : S_FIN;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LDS;
         end
         S_LDS: begin
            cmd.div_start_spd = 1'b1;
            state_in          = S_WDS;
         end
         S_WDS: begin
            if (stat.div_done) begin
               cmd.spd_write = 1'b1;
               state_in      = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.spd_zero) begin
               state_in = S_FIN;
            end else if (stat.spd_below) begin
               cmd.duty_zero = 1'b1;
               state_in      = S_FIN;
            end else if (stat.curve_empty) begin
               cmd.duty_full = 1'b1;
               state_in      = S_FIN;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            cmd.dmul = 1'b1;
            state_in = S_LDD;
         end
         S_LDD: begin
            cmd.div_start_duty = 1'b1;
            state_in           = S_WDD;
         end
         S_WDD: begin
            if (stat.div_done) begin
               state_in = S_DUTY;
            end
         end
         S_DUTY: begin
            cmd.duty_write = 1'b1;
            state_in       = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= wsfd_pkg::ST_UPDATED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign out_status = status_ff;

endmodule

// ===== rtl/wheel_speed_to_fan_duty_top.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_to_fan_duty_top
// Converts wheel speed samples into a fan PWM duty.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one speed sample item per valid/ready handshake.
//   rsp_*  : one result item per sample: speed (0.01 km/h), duty, status.
//   csr_*  : register writes, index 0..5; always ready. Write only when idle.
// Sequence: a sample with a status other than updated goes straight to the
//   result register; an updated sample runs the speed division, and a second
//   division runs when the duty curve is evaluated; both divisions run on the
//   shared restoring divider, one quotient bit per cycle.
// Flow: one item at a time; req_ready is high only while idle, so a new item
//   is taken only once the last one has moved to the result register.
// Reset: registers take their default values, history is cleared, and the
//   next valid sample is taken as the first one.
// Stall: the result register holds while rsp_ready is low; a finished item
//   waits in the sequencer until the register is free, and req_ready returns
//   once it has moved there.
// ----------------------------------------------------------------------------
module wheel_speed_to_fan_duty_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_packet_length,
   input  logic [7:0]                      req_flags,
   input  logic [31:0]                     req_wheel_revs,
   input  logic [15:0]                     req_wheel_event_time,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [13:0]                     rsp_speed,
   output logic [wsfd_pkg::DUTY_BITS-1:0]  rsp_duty,
   output logic [2:0]                      rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [2:0]                      csr_index,
   input  logic [15:0]                     csr_wdata
);

   wsfd_pkg::cmd_type    cmd;
   wsfd_pkg::stat_type   stat;
   wsfd_pkg::status_type out_status;

   assign csr_ready = 1'b1;

   wsfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd),
      .out_status (out_status)
   );

   wsfd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .out_status           (out_status),
      .csr_we               (csr_valid & csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_packet_length    (req_packet_length),
      .req_flags            (req_flags),
      .req_wheel_revs       (req_wheel_revs),
      .req_wheel_event_time (req_wheel_event_time),
      .rsp_speed            (rsp_speed),
      .rsp_duty             (rsp_duty),
      .rsp_status           (rsp_status)
   );

endmodule

// ===== rtl/wsfd_checker.sv =====
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks of the wheel speed to fan duty block, bound to the top.
// ----------------------------------------------------------------------------
`include "wheel_speed_to_fan_duty_top_assert.svh"

module wsfd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [13:0]                     rsp_speed,
   input  logic [wsfd_pkg::DUTY_BITS-1:0]  rsp_duty,
   input  logic [2:0]                      rsp_status
);

   `WSFD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed) && $stable(rsp_duty) && $stable(rsp_status), "result item changed while stalled")
   `WSFD_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "second item taken while busy")
   `WSFD_ASSERT(a_zero_interval, rsp_valid && rsp_status == wsfd_pkg::ST_ZERO_INT |-> rsp_speed == 14'd0 && rsp_duty == '0, "zero interval with nonzero output")
   `WSFD_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid && req_ready, "not idle after reset")

endmodule

bind wheel_speed_to_fan_duty_top wsfd_checker u_wsfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_speed  (rsp_speed),
   .rsp_duty   (rsp_duty),
   .rsp_status (rsp_status)
);

// ===== tb/wheel_speed_to_fan_duty_top_tb.sv =====
// ----------------------------------------------------------------------------
// Wheel speed to fan duty testbench
// Drives speed samples and register writes, predicts speed, duty and status
// for every item, and compares each result item field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wheel_speed_to_fan_duty_top_tb;

   typedef struct {
      logic [7:0]  plen;
      logic [7:0]  flg;
      logic [31:0] revs;
      logic [15:0] etime;
   } sample_type;

   typedef struct {
      logic [13:0]                    spd;
      logic [wsfd_pkg::DUTY_BITS-1:0] dty;
      wsfd_pkg::status_type           st;
   } fan_result_type;

   typedef struct {
      sample_type     smp;
      bit             known;
      fan_result_type res;
   } table_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic [7:0] req_packet_length = 0, req_flags = 0;
   logic [31:0] req_wheel_revs = 0;
   logic [15:0] req_wheel_event_time = 0;
   logic [2:0] csr_index = 0;
   logic [15:0] csr_wdata = 0;
   logic req_ready, rsp_valid, csr_ready;
   logic [13:0] rsp_speed;
   logic [wsfd_pkg::DUTY_BITS-1:0] rsp_duty;
   logic [2:0] rsp_status;

   wheel_speed_to_fan_duty_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [11:0] circ;
   logic [13:0] min_spd, max_spd, cap;
   logic [6:0]  floor_pct;
   logic [7:0]  curve_pct;
   logic [31:0] last_revs;
   logic [15:0] last_time;
   bit          first_due;
   logic [13:0] speed_now;
   logic [wsfd_pkg::DUTY_BITS-1:0] duty_now;

   fan_result_type pending_results[$];
   int errors = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_off = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic logic [wsfd_pkg::DUTY_BITS-1:0] duty_for(input logic [13:0] s);
      longint unsigned d, d2, x, q;
      if (s < min_spd) return '0;
      if (max_spd <= min_spd) return wsfd_pkg::DUTY_FULL;
      d = 64'(max_spd) - 64'(min_spd);
      d2 = d * d;
      x = 64'(s) - 64'(min_spd);
      q = (64'(wsfd_pkg::DUTY_FULL) * (64'(floor_pct) * d2 + 64'(curve_pct) * x * x))
          / (64'd100 * d2);
      if (q > 64'(wsfd_pkg::DUTY_FULL)) q = 64'(wsfd_pkg::DUTY_FULL);
      return q[wsfd_pkg::DUTY_BITS-1:0];
   endfunction

   function automatic fan_result_type predict_fan(input sample_type smp);
      fan_result_type r;
      logic [31:0] dr;
      logic [15:0] dt;
      longint unsigned s;
      if (smp.plen == 8'd0) r.st = wsfd_pkg::ST_SHORT;
      else if ((smp.flg & wsfd_pkg::FLAG_WHEEL) == 8'd0) r.st = wsfd_pkg::ST_NO_WHEEL;
      else if (smp.plen < wsfd_pkg::WHEEL_MIN_LEN) r.st = wsfd_pkg::ST_SHORT;
      else if (first_due) begin
         first_due = 0;
         r.st = wsfd_pkg::ST_FIRST;
         last_revs = smp.revs;
         last_time = smp.etime;
      end else begin
         dr = smp.revs - last_revs;
         dt = smp.etime - last_time;
         if (dt == 16'd0) begin
            speed_now = '0;
            duty_now = '0;
            r.st = wsfd_pkg::ST_ZERO_INT;
         end else begin
            s = (64'(dr) * 64'(circ) * 64'd36864) / (64'd100 * 64'(dt));
            if (s > 64'(cap)) s = 64'(cap);
            speed_now = s[13:0];
            if (speed_now > 14'd0) duty_now = duty_for(speed_now);
            r.st = wsfd_pkg::ST_UPDATED;
         end
         last_revs = smp.revs;
         last_time = smp.etime;
      end
      r.spd = speed_now;
      r.dty = duty_now;
      return r;
   endfunction

   task automatic write_reg(input wsfd_pkg::reg_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         wsfd_pkg::REG_CIRC:      circ = val[11:0];
         wsfd_pkg::REG_MIN_SPEED: min_spd = val[13:0];
         wsfd_pkg::REG_MAX_SPEED: max_spd = val[13:0];
         wsfd_pkg::REG_SPEED_CAP: cap = val[13:0];
         wsfd_pkg::REG_FLOOR_PCT: floor_pct = val[6:0];
         wsfd_pkg::REG_CURVE_PCT: curve_pct = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // called at a falling edge; returns at the falling edge after the accept
   task automatic send_sample(input sample_type smp, input bit known,
                              input fan_result_type want);
      fan_result_type r;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_packet_length <= smp.plen;
      req_flags <= smp.flg;
      req_wheel_revs <= smp.revs;
      req_wheel_event_time <= smp.etime;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_fan(smp);
      if (known && (r.spd != want.spd || r.dty != want.dty || r.st != want.st))
         report("table row", r.st, want.st);
      pending_results.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain;
      int n = 0;
      req_valid <= 0;
      while (pending_results.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (60) @(posedge clock);
   endtask

   // receiver side
   always @(negedge clock) begin
      if (!reset)
         rsp_ready <= !hold_off && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      fan_result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected result item", 1, 0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_speed != w.spd) report("speed", rsp_speed, w.spd);
            if (rsp_duty != w.dty) report("duty", rsp_duty, w.dty);
            if (rsp_status != w.st) report("status", rsp_status, w.st);
         end
      end
   end

   function automatic sample_type rand_sample(input bit wellformed);
      sample_type s;
      s.plen = wellformed ? 8'($urandom_range(255, 7)) : 8'($urandom);
      s.flg = wellformed ? (8'($urandom) | wsfd_pkg::FLAG_WHEEL) : 8'($urandom);
      s.revs = last_revs + (($urandom_range(9) == 0) ? $urandom : $urandom_range(12));
      case ($urandom_range(9))
         0: s.etime = last_time;
         1: s.etime = 16'($urandom);
         default: s.etime = last_time + 16'($urandom_range(4000, 1));
      endcase
      return s;
   endfunction

   task automatic random_config(input int pick);
      case (pick)
         0: begin
            write_reg(wsfd_pkg::REG_CIRC, 16'd4000);
            write_reg(wsfd_pkg::REG_MIN_SPEED, 16'd0);
            write_reg(wsfd_pkg::REG_MAX_SPEED, 16'd9900);
            write_reg(wsfd_pkg::REG_SPEED_CAP, 16'd9900);
            write_reg(wsfd_pkg::REG_FLOOR_PCT, 16'd100);
            write_reg(wsfd_pkg::REG_CURVE_PCT, 16'd200);
         end
         1: begin
            write_reg(wsfd_pkg::REG_CIRC, 16'd100);
            write_reg(wsfd_pkg::REG_MIN_SPEED, 16'd9900);
            write_reg(wsfd_pkg::REG_MAX_SPEED, 16'd1);
            write_reg(wsfd_pkg::REG_SPEED_CAP, 16'd0);
            write_reg(wsfd_pkg::REG_FLOOR_PCT, 16'd0);
            write_reg(wsfd_pkg::REG_CURVE_PCT, 16'd0);
         end
         2: begin
            write_reg(wsfd_pkg::REG_CIRC, 16'hFFFF);
            write_reg(wsfd_pkg::REG_MIN_SPEED, 16'hFFFF);
            write_reg(wsfd_pkg::REG_MAX_SPEED, 16'hFFFF);
            write_reg(wsfd_pkg::REG_SPEED_CAP, 16'hFFFF);
            write_reg(wsfd_pkg::REG_FLOOR_PCT, 16'hFFFF);
            write_reg(wsfd_pkg::REG_CURVE_PCT, 16'hFFFF);
         end
         default: begin
            write_reg(wsfd_pkg::REG_CIRC, 16'($urandom_range(4000, 100)));
            write_reg(wsfd_pkg::REG_MIN_SPEED, 16'($urandom_range(2000)));
            write_reg(wsfd_pkg::REG_MAX_SPEED, 16'($urandom_range(9900, 1)));
            write_reg(wsfd_pkg::REG_SPEED_CAP, 16'($urandom_range(9900)));
            write_reg(wsfd_pkg::REG_FLOOR_PCT, 16'($urandom_range(100)));
            write_reg(wsfd_pkg::REG_CURVE_PCT, 16'($urandom_range(200)));
         end
      endcase
   endtask

   initial begin
      table_row_type rows[$];
      fan_result_type none;
      circ = 2146; min_spd = 300; max_spd = 3500; cap = 9900;
      floor_pct = 4; curve_pct = 98;
      last_revs = 0; last_time = 0; first_due = 1; speed_now = 0; duty_now = 0;
      none = '{14'd0, '0, wsfd_pkg::ST_UPDATED};
      // directed table: fixed answers where obvious, predictor otherwise
      rows.push_back('{'{8'd0, 8'hFF, 32'd5, 16'd5}, 1,
                       '{14'd0, '0, wsfd_pkg::ST_SHORT}});
      rows.push_back('{'{8'd255, 8'hFE, 32'd5, 16'd5}, 1,
                       '{14'd0, '0, wsfd_pkg::ST_NO_WHEEL}});
      rows.push_back('{'{8'd6, 8'h01, 32'd5, 16'd5}, 1,
                       '{14'd0, '0, wsfd_pkg::ST_SHORT}});
      rows.push_back('{'{8'd7, 8'h01, 32'd100, 16'd1000}, 1,
                       '{14'd0, '0, wsfd_pkg::ST_FIRST}});
      rows.push_back('{'{8'd7, 8'h01, 32'd101, 16'd2024}, 0, none});
      rows.push_back('{'{8'd255, 8'hFF, 32'd105, 16'd3048}, 0, none});
      rows.push_back('{'{8'd7, 8'h01, 32'd105, 16'd4072}, 0, none});
      rows.push_back('{'{8'd7, 8'h01, 32'd110, 16'd4072}, 1,
                       '{14'd0, '0, wsfd_pkg::ST_ZERO_INT}});
      rows.push_back('{'{8'd7, 8'h01, 32'hFFFF_FFFF, 16'hFFFF}, 0, none});
      rows.push_back('{'{8'd7, 8'h01, 32'd2, 16'd1}, 0, none});
      rows.push_back('{'{8'd7, 8'h01, 32'd3, 16'd0}, 0, none});
      rows.push_back('{'{8'd7, 8'h01, 32'd4, 16'd1023}, 0, none});
      rows.push_back('{'{8'd7, 8'h01, 32'd5, 16'd2046}, 0, none});
      rows.push_back('{'{8'd7, 8'h01, 32'd5, 16'd3000}, 0, none});
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (rows[i]) send_sample(rows[i].smp, rows[i].known, rows[i].res);
      drain();
      for (int ph = 0; ph < 12; ph++) begin
         random_config(ph);
         case (ph % 3)
            0: begin send_idle = 26; recv_idle = 68; end
            1: begin send_idle = 68; recv_idle = 26; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         if (ph == 4) fork
            begin hold_off = 1; repeat (300) @(posedge clock); hold_off = 0; end
         join_none
         for (int k = 0; k < 155; k++)
            send_sample(rand_sample($urandom_range(9) != 0), 0, none);
         drain();
      end
      if (pending_results.size() != 0)
         report("missing result items", pending_results.size(), 0);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
